[src/msh_pkg.sv]
// ----------------------------------------------------------------------------
// msh_pkg: shared types and constants of the MD5 stream hasher
// Round constants, rotate and message-index schedules, state types and the
// control group that the byte sequencer drives into the round core.
// ----------------------------------------------------------------------------
package msh_pkg;

  typedef logic [3:0][31:0] chain_t;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;

  localparam logic [7:0] PAD_MARK  = 8'h80;
  localparam logic [5:0] POS_LAST  = 6'h3F;
  localparam logic [5:0] POS_LEN   = 6'd56;
  localparam logic [5:0] ROUND_END = 6'd63;

  localparam logic [31:0] ROUND_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_AMT [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD_MARK,
    ST_PAD_ZERO,
    ST_PAD_LEN,
    ST_COMP,
    ST_DONE
  } hash_state_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_LOAD,
    CS_ROUND,
    CS_ADD
  } core_state_t;

  typedef struct packed {
    logic start;
    logic init;
  } core_ctrl_t;

  // message word used by a round
  function automatic logic [3:0] msg_index(input logic [5:0] i);
    logic [3:0] lo;
    lo = i[3:0];
    unique case (i[5:4])
      2'd0: return lo;
      2'd1: return 4'(lo * 4'd5 + 4'd1);
      2'd2: return 4'(lo * 4'd3 + 4'd5);
      2'd3: return 4'(lo * 4'd7);
    endcase
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] i);
    return ROT_AMT[{i[5:4], i[1:0]}];
  endfunction

  function automatic logic [31:0] round_f(input logic [1:0] sel, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    unique case (sel)
      2'd0: return (b & c) | (~b & d);
      2'd1: return (d & b) | (~d & c);
      2'd2: return b ^ c ^ d;
      2'd3: return c ^ (b | ~d);
    endcase
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
    logic [63:0] dbl;
    dbl = {v, v} << s;
    return dbl[63:32];
  endfunction

endpackage

[src/msh_ifs.sv]
// ----------------------------------------------------------------------------
// msh_ifs: channel interfaces of the MD5 stream hasher
// Byte word channel into the block and digest word channel out of it.
// ----------------------------------------------------------------------------
interface msh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       empty_message;

  modport source(output valid, output data_byte, output last_byte,
                 output empty_message, input ready);
  modport sink(input valid, input data_byte, input last_byte,
               input empty_message, output ready);
endinterface

interface msh_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_low;
  logic [63:0] digest_high;
  logic [31:0] folded_checksum;

  modport source(output valid, output digest_low, output digest_high,
                 output folded_checksum, input ready);
  modport sink(input valid, input digest_low, input digest_high,
               input folded_checksum, output ready);
endinterface

[src/msh_block_buf.sv]
// ----------------------------------------------------------------------------
// msh_block_buf: 64-byte block store
// Written one byte per cycle, read one little-endian 32-bit word per cycle
// with registered read data.
// ----------------------------------------------------------------------------
module msh_block_buf (
  input  logic        clk,
  input  logic        we,
  input  logic [5:0]  wpos,
  input  logic [7:0]  wdata,
  input  logic [3:0]  raddr,
  output logic [31:0] rdata
);

  logic [3:0][7:0] mem [16];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wpos[5:2]][wpos[1:0]] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/msh_round_core.sv]
// ----------------------------------------------------------------------------
// msh_round_core: iterative MD5 compression
// One shared round datapath runs 64 rounds, one per cycle, then folds the
// working words into the chaining words.
// ----------------------------------------------------------------------------
module msh_round_core (
  input  logic                clk,
  input  logic                rst,
  input  msh_pkg::core_ctrl_t ctrl,
  input  logic [31:0]         rdata,
  output logic [3:0]          raddr,
  output logic                done,
  output msh_pkg::chain_t     chain
);
  import msh_pkg::*;

  core_state_t state, state_next;
  logic [5:0]  round;
  logic [31:0] a, b, c, d;
  logic [31:0] t_sum;
  logic [31:0] b_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    done       = 1'b0;
    raddr      = msg_index(6'd0);
    unique case (state)
      CS_IDLE: begin
        if (ctrl.start) begin
          state_next = CS_LOAD;
        end
      end
      CS_LOAD: begin
        state_next = CS_ROUND;
      end
      CS_ROUND: begin
        // fetch the word for the following round
        raddr = msg_index(round + 6'd1);
        if (round == ROUND_END) begin
          state_next = CS_ADD;
        end
      end
      CS_ADD: begin
        done       = 1'b1;
        state_next = CS_IDLE;
      end
    endcase
  end

  assign t_sum = a + round_f(round[5:4], b, c, d) + rdata + ROUND_K[round];
  assign b_new = b + rotl32(t_sum, rot_amount(round));

  always_ff @(posedge clk) begin
    unique case (state)
      CS_LOAD: begin
        a     <= chain[0];
        b     <= chain[1];
        c     <= chain[2];
        d     <= chain[3];
        round <= 6'd0;
      end
      CS_ROUND: begin
        a     <= d;
        d     <= c;
        c     <= b;
        b     <= b_new;
        round <= round + 6'd1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.init) begin
      chain <= {INIT_D, INIT_C, INIT_B, INIT_A};
    end else if (state == CS_ADD) begin
      chain[0] <= chain[0] + a;
      chain[1] <= chain[1] + b;
      chain[2] <= chain[2] + c;
      chain[3] <= chain[3] + d;
    end
  end

endmodule

[src/md5_stream_hasher.sv]
// ----------------------------------------------------------------------------
// md5_stream_hasher: byte-serial MD5 digest
// Gathers message bytes into 64-byte blocks, compresses each full block,
// pads at message end and delivers the digest with its XOR fold.
//
//   channel     role  word contents
//   data_in     sink  data_byte, last_byte, empty_message
//   digest_out  src   digest_low, digest_high, folded_checksum
//
// Message bytes are taken one per cycle while the sequencer is idle; each
// full block then passes the round core as one load, 64 rounds on the shared
// round unit and one fold. Padding writes one byte per cycle between
// compressions, idling a step on reaching offset 56, and a last step moves
// the digest into the output register. Reset is synchronous; the block store
// needs no clear. A waiting digest stalls only the next message's finish.
// ----------------------------------------------------------------------------
module md5_stream_hasher (
  input  logic      clk,
  input  logic      rst,
  msh_in_if.sink    data_in,
  msh_out_if.source digest_out
);
  import msh_pkg::*;

  hash_state_t state, state_next;
  hash_state_t ret_state, ret_next;
  logic [5:0]  pos, pos_next;
  logic [63:0] bit_count;
  logic        count_inc;
  logic        count_clr;
  logic        in_fire;
  logic        we;
  logic [7:0]  wdata;
  logic [31:0] rdata;
  logic [3:0]  raddr;
  logic        core_done;
  logic        load_out;
  core_ctrl_t  ctrl;
  chain_t      chain;

  assign in_fire = data_in.valid && data_in.ready;

  msh_block_buf u_buf (
    .clk  (clk),
    .we   (we),
    .wpos (pos),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  msh_round_core u_core (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .rdata(rdata),
    .raddr(raddr),
    .done (core_done),
    .chain(chain)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ret_state <= ST_IDLE;
      pos       <= 6'd0;
    end else begin
      state     <= state_next;
      ret_state <= ret_next;
      pos       <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || count_clr) begin
      bit_count <= 64'd0;
    end else if (count_inc) begin
      bit_count <= bit_count + 64'd8;
    end
  end

  always_comb begin
    state_next    = state;
    ret_next      = ret_state;
    pos_next      = pos;
    we            = 1'b0;
    wdata         = 8'd0;
    count_inc     = 1'b0;
    count_clr     = 1'b0;
    load_out      = 1'b0;
    ctrl          = '0;
    data_in.ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        data_in.ready = 1'b1;
        if (in_fire) begin
          if (!data_in.empty_message) begin
            we        = 1'b1;
            wdata     = data_in.data_byte;
            count_inc = 1'b1;
            pos_next  = pos + 6'd1;
          end
          priority if (!data_in.empty_message && pos == POS_LAST) begin
            ctrl.start = 1'b1;
            state_next = ST_COMP;
            ret_next   = data_in.last_byte ? ST_PAD_MARK : ST_IDLE;
          end else if (data_in.last_byte || data_in.empty_message) begin
            state_next = ST_PAD_MARK;
          end else begin
          end
        end
      end
      ST_PAD_MARK: begin
        we       = 1'b1;
        wdata    = PAD_MARK;
        pos_next = pos + 6'd1;
        ret_next = ST_PAD_ZERO;
        if (pos == POS_LAST) begin
          ctrl.start = 1'b1;
          state_next = ST_COMP;
        end else begin
          state_next = ST_PAD_ZERO;
        end
      end
      ST_PAD_ZERO: begin
        if (pos == POS_LEN) begin
          state_next = ST_PAD_LEN;
        end else begin
          we       = 1'b1;
          pos_next = pos + 6'd1;
          if (pos == POS_LAST) begin
            ctrl.start = 1'b1;
            ret_next   = ST_PAD_ZERO;
            state_next = ST_COMP;
          end
        end
      end
      ST_PAD_LEN: begin
        // length bytes sit at offsets 56..63, little-endian
        we       = 1'b1;
        wdata    = bit_count[{pos[2:0], 3'b000} +: 8];
        pos_next = pos + 6'd1;
        if (pos == POS_LAST) begin
          ctrl.start = 1'b1;
          ret_next   = ST_DONE;
          state_next = ST_COMP;
        end
      end
      ST_COMP: begin
        if (core_done) begin
          state_next = ret_state;
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!digest_out.valid || digest_out.ready) begin
          load_out   = 1'b1;
          ctrl.init  = 1'b1;
          count_clr  = 1'b1;
          pos_next   = 6'd0;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digest_out.valid <= 1'b0;
    end else if (load_out) begin
      digest_out.valid <= 1'b1;
    end else if (digest_out.ready) begin
      digest_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      digest_out.digest_low      <= {chain[1], chain[0]};
      digest_out.digest_high     <= {chain[3], chain[2]};
      digest_out.folded_checksum <= chain[0] ^ chain[1] ^ chain[2] ^ chain[3];
    end
  end

endmodule

[src/msh_checker.sv]
// ----------------------------------------------------------------------------
// msh_checker: port-level checks of the MD5 stream hasher
// Watches both channels over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module msh_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        last_byte,
  input logic        empty_message,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] digest_low,
  input logic [63:0] digest_high,
  input logic [31:0] folded_checksum
);

  // a stalled digest word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(digest_low) &&
      $stable(digest_high) && $stable(folded_checksum))
    else $error("digest word changed or dropped while stalled");

  // a message end starts padding, so no byte is taken next cycle
  a_end_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (last_byte || empty_message) |=> !in_ready)
    else $error("byte accepted right after message end");

  // a new digest appears only as the block leaves its finishing phase
  a_digest_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("digest appeared while taking bytes");

  // reset leaves the block empty and ready
  a_reset_state: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind md5_stream_hasher msh_checker u_msh_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (data_in.valid),
  .in_ready       (data_in.ready),
  .last_byte      (data_in.last_byte),
  .empty_message  (data_in.empty_message),
  .out_valid      (digest_out.valid),
  .out_ready      (digest_out.ready),
  .digest_low     (digest_out.digest_low),
  .digest_high    (digest_out.digest_high),
  .folded_checksum(digest_out.folded_checksum)
);

[test/md5_stream_hasher_test.sv]
// ----------------------------------------------------------------------------
// md5_stream_hasher_test: self-checking bench for the MD5 stream hasher
// Feeds whole messages one byte word at a time. A local MD5 computation
// predicts every digest and its XOR fold. Both channels idle in random bursts,
// and the digest side holds off once for a long stretch. Random messages
// cluster around the padding boundaries of one and two blocks.
// ----------------------------------------------------------------------------
module md5_stream_hasher_test;
  timeunit 1ns;
  timeprecision 1ps;

  import msh_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 300;
  localparam int CALM_WORDS = 250;
  localparam int TARGET_WORDS = 2000;
  localparam int unsigned SHIFT_BY [16] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_OFFSET = 6'd56;
  localparam logic [5:0] BLOCK_END = 6'd63;

  typedef enum int {
    END_ON_LAST,
    END_ON_MARKER,
    END_ON_BOTH
  } msg_end_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       empty;
  } byte_word_t;

  typedef struct packed {
    logic [63:0] low;
    logic [63:0] high;
    logic [31:0] fold;
  } digest_word_t;

  logic clk;
  logic rst;

  msh_in_if  byte_ch();
  msh_out_if digest_ch();

  md5_stream_hasher DUT (
    .clk       (clk),
    .rst       (rst),
    .data_in   (byte_ch),
    .digest_out(digest_ch)
  );

  always #1 clk = ~clk;

  byte_word_t   msg_words [$];
  digest_word_t digests_due [$];
  int           words_total;
  int           words_sent;
  int           errors;
  logic         calm;

  // predictor state
  logic [31:0] chain [4];
  logic [7:0]  blk [64];
  logic [63:0] msg_bits;
  logic [5:0]  fill_pos;

  function automatic void reset_chain();
    chain[0] = INIT_A;
    chain[1] = INIT_B;
    chain[2] = INIT_C;
    chain[3] = INIT_D;
    msg_bits = '0;
    fill_pos = '0;
  endfunction

  function automatic void compress_block();
    logic [31:0] m [16];
    logic [31:0] a, b, c, d, f, t;
    int unsigned k, s;
    int i;
    for (i = 0; i < 16; i++)
      m[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    for (i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin
          f = (b & c) | (~b & d);
          k = i;
        end
        1: begin
          f = (d & b) | (~d & c);
          k = (5 * i + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          k = (3 * i + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          k = (7 * i) % 16;
        end
      endcase
      s = SHIFT_BY[(i / 16) * 4 + (i % 4)];
      t = a + f + m[k] + ROUND_K[i];
      a = d;
      d = c;
      c = b;
      b = b + ((t << s) | (t >> (32 - s)));
    end
    chain[0] += a;
    chain[1] += b;
    chain[2] += c;
    chain[3] += d;
  endfunction

  function automatic void store_byte(input logic [7:0] v);
    blk[fill_pos] = v;
    if (fill_pos == BLOCK_END)
      compress_block();
    fill_pos = fill_pos + 6'd1;
  endfunction

  function automatic void close_message();
    logic [63:0] len;
    digest_word_t dg;
    int i;
    len = msg_bits;
    store_byte(PAD_BYTE);
    while (fill_pos != LEN_OFFSET)
      store_byte(8'h00);
    for (i = 0; i < 8; i++)
      store_byte(len[8*i +: 8]);
    dg.low  = {chain[1], chain[0]};
    dg.high = {chain[3], chain[2]};
    dg.fold = chain[0] ^ chain[1] ^ chain[2] ^ chain[3];
    digests_due.push_back(dg);
    reset_chain();
  endfunction

  function automatic void hash_word(input byte_word_t w);
    if (!w.empty) begin
      store_byte(w.data);
      msg_bits += 64'd8;
    end
    if (w.empty || w.last)
      close_message();
  endfunction

  function automatic void push_word(input logic [7:0] data, input logic last,
                                    input logic empty);
    byte_word_t w;
    w.data  = data;
    w.last  = last;
    w.empty = empty;
    msg_words.push_back(w);
  endfunction

  // bytes of random content, closed the way the ending asks
  function automatic void push_message(input int len, input msg_end_t ending);
    int i;
    for (i = 0; i < len; i++) begin
      if (i == len - 1 && ending == END_ON_LAST)
        push_word(8'($urandom_range(0, 255)), 1'b1, 1'b0);
      else
        push_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    end
    if (ending == END_ON_MARKER || (len == 0 && ending == END_ON_LAST))
      push_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    else if (ending == END_ON_BOTH)
      push_word(8'($urandom_range(0, 255)), 1'b1, 1'b1);
  endfunction

  function automatic int pick_length();
    int edges [10];
    edges = '{54, 55, 56, 57, 63, 64, 65, 119, 120, 121};
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 3);
      1, 2, 3: return $urandom_range(1, 40);
      4, 5, 6: return edges[$urandom_range(0, 9)];
      7:       return $urandom_range(66, 200);
      default: return $urandom_range(0, 130);
    endcase
  endfunction

  // byte word driver
  int   send_gap;
  int   send_odds;
  byte_word_t nxt;

  always @(posedge clk) begin
    if (rst) begin
      byte_ch.valid <= 1'b0;
      send_gap = 0;
      send_odds = 0;
    end else begin
      if (byte_ch.valid && byte_ch.ready) begin
        hash_word({byte_ch.data_byte, byte_ch.last_byte, byte_ch.empty_message});
        words_sent++;
      end
      calm <= (msg_words.size() < CALM_WORDS);
      if (!byte_ch.valid || byte_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          byte_ch.valid <= 1'b0;
        end else if (msg_words.size() != 0) begin
          nxt = msg_words.pop_front();
          byte_ch.valid         <= 1'b1;
          byte_ch.data_byte     <= nxt.data;
          byte_ch.last_byte     <= nxt.last;
          byte_ch.empty_message <= nxt.empty;
          // change idling intensity at message ends, zero means none
          if (nxt.last || nxt.empty)
            send_odds = $urandom_range(0, 3);
          if (!calm && send_odds != 0 && $urandom_range(1, 8) <= send_odds)
            send_gap = $urandom_range(1, 10);
        end else begin
          byte_ch.valid <= 1'b0;
        end
      end
    end
  end

  // digest receiver
  int   recv_gap;
  int   recv_odds;
  int   hold_left;
  int   taken;
  logic held;

  always @(posedge clk) begin
    if (rst) begin
      digest_ch.ready <= 1'b0;
      recv_gap = 0;
      recv_odds = 0;
      hold_left = 0;
      taken = 0;
      held = 1'b0;
    end else begin
      if (digest_ch.valid && digest_ch.ready) begin
        taken++;
        recv_odds = $urandom_range(0, 3);
        if (!calm && recv_odds != 0 && $urandom_range(1, 8) <= recv_odds)
          recv_gap = $urandom_range(1, 10);
      end
      // one long hold while the sender keeps pushing bytes
      if (!held && taken == 3) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        digest_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        digest_ch.ready <= 1'b0;
      end else begin
        digest_ch.ready <= 1'b1;
      end
    end
  end

  // digest checker
  digest_word_t want;

  always @(posedge clk) begin
    if (!rst && digest_ch.valid && digest_ch.ready) begin
      if (digests_due.size() == 0) begin
        $display("%0t: digest with none expected: low=%h high=%h fold=%h", $time,
                 digest_ch.digest_low, digest_ch.digest_high, digest_ch.folded_checksum);
        errors++;
      end else begin
        want = digests_due.pop_front();
        if (digest_ch.digest_low !== want.low) begin
          $display("%0t: digest_low expected %h actual %h", $time, want.low,
                   digest_ch.digest_low);
          errors++;
        end
        if (digest_ch.digest_high !== want.high) begin
          $display("%0t: digest_high expected %h actual %h", $time, want.high,
                   digest_ch.digest_high);
          errors++;
        end
        if (digest_ch.folded_checksum !== want.fold) begin
          $display("%0t: folded_checksum expected %h actual %h", $time, want.fold,
                   digest_ch.folded_checksum);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either channel
  int stall_cycles;

  always @(posedge clk) begin
    if ((byte_ch.valid && byte_ch.ready) || (digest_ch.valid && digest_ch.ready))
      stall_cycles <= 0;
    else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("Verification failed");
      $finish;
    end else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    calm = 1'b0;
    stall_cycles = 0;
    words_sent = 0;
    errors = 0;
    byte_ch.valid = 1'b0;
    byte_ch.data_byte = 8'h00;
    byte_ch.last_byte = 1'b0;
    byte_ch.empty_message = 1'b0;
    digest_ch.ready = 1'b0;
    reset_chain();

    // empty message, by marker alone and by both flags with data ignored
    push_word(8'h00, 1'b0, 1'b1);
    push_word(8'hFF, 1'b1, 1'b1);
    // one-byte messages at the byte extremes
    push_word(8'hFF, 1'b1, 1'b0);
    push_word(8'h00, 1'b1, 1'b0);
    // "abc"
    push_word(8'h61, 1'b0, 1'b0);
    push_word(8'h62, 1'b0, 1'b0);
    push_word(8'h63, 1'b1, 1'b0);
    // marker after bytes adds no byte
    push_word(8'h55, 1'b0, 1'b0);
    push_word(8'hAA, 1'b0, 1'b0);
    push_word(8'hFF, 1'b0, 1'b1);
    // both flags after a byte: the flagged data is dropped
    push_word(8'h7F, 1'b0, 1'b0);
    push_word(8'h80, 1'b1, 1'b1);

    while (msg_words.size() < TARGET_WORDS)
      push_message(pick_length(), msg_end_t'($urandom_range(0, 2)));
    words_total = msg_words.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (words_sent != words_total)
      @(posedge clk);
    while (digests_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
